// ===== rtl/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants of the line rasterizer: field widths, register
// indexes, reset values and the per-point flag group.
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

  localparam int unsigned CoordBitsDefault = 12;
  localparam int unsigned StrideBits       = 13;
  localparam int unsigned ColorBits        = 32;
  localparam int unsigned ClipBits         = 12;
  localparam int unsigned AddrBits         = 24;
  localparam int unsigned CfgIndexBits     = 2;
  localparam int unsigned CfgDataBits      = 32;

  localparam logic [StrideBits-1:0] StrideReset = StrideBits'(600);
  localparam logic [ColorBits-1:0]  ColorReset  = 32'h00FF_FFFF;
  localparam logic [ClipBits-1:0]   ClipWReset  = ClipBits'(600);
  localparam logic [ClipBits-1:0]   ClipHReset  = ClipBits'(600);

  typedef enum logic [CfgIndexBits-1:0] {
    CfgStride = 2'd0,
    CfgColor  = 2'd1,
    CfgClipW  = 2'd2,
    CfgClipH  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ReqStart   = 1'b0,
    ReqAdvance = 1'b1
  } req_e;

  typedef struct packed {
    logic write_en;
    logic done;
  } pt_flags_t;

endpackage

`default_nettype wire

// ===== rtl/brl_step.sv =====
// ----------------------------------------------------------------------------
// brl_step
// Line state and one error step per advance beat on an active line. Produces the point that the
// accepted beat emits, with its clip and end-of-line flags.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_step #(
  parameter int unsigned COORD_BITS = brl_pkg::CoordBitsDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               step_en_i,
  input  wire logic                               req_type_i,
  input  wire logic signed [COORD_BITS-1:0]       start_x_i,
  input  wire logic signed [COORD_BITS-1:0]       start_y_i,
  input  wire logic signed [COORD_BITS-1:0]       end_x_i,
  input  wire logic signed [COORD_BITS-1:0]       end_y_i,
  input  wire logic        [brl_pkg::ClipBits-1:0] clip_w_i,
  input  wire logic        [brl_pkg::ClipBits-1:0] clip_h_i,
  output logic signed      [COORD_BITS-1:0]       pt_x_o,
  output logic signed      [COORD_BITS-1:0]       pt_y_o,
  output brl_pkg::pt_flags_t                      pt_flags_o
);

  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned EW  = COORD_BITS + 3;
  localparam int unsigned E2W = COORD_BITS + 4;
  localparam int unsigned CW  =
    ((COORD_BITS > brl_pkg::ClipBits) ? COORD_BITS : brl_pkg::ClipBits) + 1;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic        [DW-1:0]         dx_q, dx_d, dy_q, dy_d;
  logic                         sx_neg_q, sx_neg_d, sy_neg_q, sy_neg_d;
  logic signed [EW-1:0]         err_q, err_d;
  logic                         active_q, active_d;

  logic signed [DW-1:0]  diff_x, diff_y;
  logic        [DW-1:0]  abs_x, abs_y;
  logic signed [E2W-1:0] e2;
  logic                  step_x, step_y;
  logic                  enable;
  logic                  done;
  logic                  in_clip;

  always_comb begin
    diff_x = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
    diff_y = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
    abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
    e2     = {err_q, 1'b0};
    step_x = e2 > -$signed({3'b000, dy_q});
    step_y = e2 < $signed({3'b000, dx_q});

    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    sx_neg_d = sx_neg_q;
    sy_neg_d = sy_neg_q;
    err_d    = err_q;
    enable   = 1'b1;

    unique case (brl_pkg::req_e'(req_type_i))
      brl_pkg::ReqStart: begin
        cur_x_d  = start_x_i;
        cur_y_d  = start_y_i;
        tgt_x_d  = end_x_i;
        tgt_y_d  = end_y_i;
        dx_d     = abs_x;
        dy_d     = abs_y;
        sx_neg_d = !(start_x_i < end_x_i);
        sy_neg_d = !(start_y_i < end_y_i);
        err_d    = $signed({2'b00, abs_x}) - $signed({2'b00, abs_y});
      end
      brl_pkg::ReqAdvance: begin
        if (active_q) begin
          if (step_x) begin
            cur_x_d = sx_neg_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
          end
          if (step_y) begin
            cur_y_d = sy_neg_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
          end
          err_d = err_q - (step_x ? $signed({2'b00, dy_q}) : '0)
                        + (step_y ? $signed({2'b00, dx_q}) : '0);
        end else begin
          enable = 1'b0;
        end
      end
      default: enable = 1'b0;
    endcase

    done     = (cur_x_d == tgt_x_d) && (cur_y_d == tgt_y_d);
    in_clip  = !cur_x_d[COORD_BITS-1] && !cur_y_d[COORD_BITS-1] &&
               (CW'(unsigned'(cur_x_d)) < CW'(clip_w_i)) &&
               (CW'(unsigned'(cur_y_d)) < CW'(clip_h_i));
    active_d = enable && !done;
  end

  assign pt_x_o              = cur_x_d;
  assign pt_y_o              = cur_y_d;
  assign pt_flags_o.write_en = enable && in_clip;
  assign pt_flags_o.done     = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      sx_neg_q <= 1'b0;
      sy_neg_q <= 1'b0;
      err_q    <= '0;
      active_q <= 1'b0;
    end else if (step_en_i) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      sx_neg_q <= sx_neg_d;
      sy_neg_q <= sy_neg_d;
      err_q    <= err_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer line engine for all octants: start beats load endpoints, advance
// beats take one error step; each beat yields one output point, clip-flagged.
// Pipeline: the step stage registers the point, then the address stage.
// Throughput: one beat per cycle unless m_axis_tready holds the output; the address multiply-add sets the second stage.
// Reset: line state cleared (no active line, point at origin), registers
// return to stride 600, color 0xFFFFFF, clip 600 by 600.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer #(
  parameter int unsigned COORD_BITS = brl_pkg::CoordBitsDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [brl_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  wire logic [brl_pkg::CfgDataBits-1:0]     cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // req_type
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // pixel_x, pixel_y, word_address, pixel_color
  output logic [((2*COORD_BITS+brl_pkg::AddrBits+brl_pkg::ColorBits+7)/8)*8-1:0]
                                                   m_axis_tdata,
  // write_enable
  output logic                                     m_axis_tuser,
  // line_done
  output logic                                     m_axis_tlast
);

  localparam int unsigned N   = COORD_BITS;
  localparam int unsigned OW  =
    ((2*N + brl_pkg::AddrBits + brl_pkg::ColorBits + 7) / 8) * 8;
  localparam int unsigned PW  = N + brl_pkg::StrideBits + 1;
  localparam int unsigned XW  = (PW > brl_pkg::AddrBits) ? PW : brl_pkg::AddrBits;

  logic [brl_pkg::StrideBits-1:0] stride_q;
  logic [brl_pkg::ColorBits-1:0]  color_q;
  logic [brl_pkg::ClipBits-1:0]   clip_w_q, clip_h_q;

  logic                   accept;
  logic                   s1_valid_q, s1_valid_d;
  logic signed [N-1:0]    s1_x_q, s1_y_q;
  brl_pkg::pt_flags_t     s1_flags_q;
  logic                   out_load;
  logic                   out_valid_q, out_valid_d;
  logic signed [N-1:0]    out_x_q, out_y_q;
  logic [brl_pkg::AddrBits-1:0] out_addr_q;
  brl_pkg::pt_flags_t     out_flags_q;

  logic signed [N-1:0]    pt_x, pt_y;
  brl_pkg::pt_flags_t     pt_flags;
  logic signed [PW-1:0]   prod;
  logic signed [XW-1:0]   addr_full;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= brl_pkg::StrideReset;
      color_q  <= brl_pkg::ColorReset;
      clip_w_q <= brl_pkg::ClipWReset;
      clip_h_q <= brl_pkg::ClipHReset;
    end else if (cfg_we_i) begin
      unique case (brl_pkg::cfg_idx_e'(cfg_index_i))
        brl_pkg::CfgStride: stride_q <= cfg_wdata_i[brl_pkg::StrideBits-1:0];
        brl_pkg::CfgColor:  color_q  <= cfg_wdata_i[brl_pkg::ColorBits-1:0];
        brl_pkg::CfgClipW:  clip_w_q <= cfg_wdata_i[brl_pkg::ClipBits-1:0];
        brl_pkg::CfgClipH:  clip_h_q <= cfg_wdata_i[brl_pkg::ClipBits-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  assign out_load      = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || out_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d  = accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_q);
    out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  brl_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (accept),
    .req_type_i (s_axis_tuser),
    .start_x_i  (s_axis_tdata[N-1:0]),
    .start_y_i  (s_axis_tdata[2*N-1:N]),
    .end_x_i    (s_axis_tdata[3*N-1:2*N]),
    .end_y_i    (s_axis_tdata[4*N-1:3*N]),
    .clip_w_i   (clip_w_q),
    .clip_h_i   (clip_h_q),
    .pt_x_o     (pt_x),
    .pt_y_o     (pt_y),
    .pt_flags_o (pt_flags)
  );

  // address: y * stride + x, wrapped to the address width
  always_comb begin
    prod      = PW'(s1_y_q) * PW'($signed({1'b0, stride_q}));
    addr_full = XW'(prod) + XW'(s1_x_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= pt_x;
      s1_y_q     <= pt_y;
      s1_flags_q <= pt_flags;
    end
    if (out_load) begin
      out_x_q     <= s1_x_q;
      out_y_q     <= s1_y_q;
      out_addr_q  <= addr_full[brl_pkg::AddrBits-1:0];
      out_flags_q <= s1_flags_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OW'({color_q, out_addr_q, out_y_q, out_x_q});
  assign m_axis_tuser  = out_flags_q.write_en;
  assign m_axis_tlast  = out_flags_q.done;

endmodule

`default_nettype wire

// ===== tb/sv/bresenham_point_checker.sv =====
// ----------------------------------------------------------------------------
// bresenham_point_checker
// Watches the register port and both stream channels of the line rasterizer.
// Every accepted input beat is stepped through a line tracer kept here, which
// queues the point it should produce; every output beat is compared field by
// field with the oldest queued point. Mismatch count and the number of points
// still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module bresenham_point_checker import brl_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  cfg_we_i,
  input  logic [CfgIndexBits-1:0]                               cfg_index_i,
  input  logic [CfgDataBits-1:0]                                cfg_wdata_i,
  input  logic                                                  s_axis_tvalid,
  input  logic                                                  s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]                     s_axis_tdata,
  // req_type
  input  logic                                                  s_axis_tuser,
  input  logic                                                  m_axis_tvalid,
  input  logic                                                  m_axis_tready,
  // pixel_x, pixel_y, word_address, pixel_color
  input  logic [((2*COORD_BITS+AddrBits+ColorBits+7)/8)*8-1:0]  m_axis_tdata,
  // write_enable
  input  logic                                                  m_axis_tuser,
  // line_done
  input  logic                                                  m_axis_tlast,
  output int                                                    mismatch_count_o,
  output int                                                    points_pending_o
);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t end_y;
    coord_t end_x;
    coord_t start_y;
    coord_t start_x;
  } endpoints_t;

  typedef struct packed {
    logic [ColorBits-1:0] color;
    logic [AddrBits-1:0]  addr;
    coord_t               y;
    coord_t               x;
  } pixel_beat_t;

  typedef struct packed {
    pt_flags_t   flags;
    pixel_beat_t body;
  } point_t;

  logic [StrideBits-1:0] stride;
  logic [ColorBits-1:0]  fill_color;
  logic [ClipBits-1:0]   clip_w;
  logic [ClipBits-1:0]   clip_h;

  coord_t                  pos_x, pos_y, goal_x, goal_y;
  logic [COORD_BITS:0]     span_x, span_y;
  logic                    step_x_neg, step_y_neg;
  logic signed [COORD_BITS+2:0] err;
  logic                    drawing;

  point_t expected_points[$];
  int     mismatches = 0;
  int     beats_seen = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (mismatches < 100) begin
      $display("point %0d: %s is %0h, expected %0h", beats_seen, field, got, want);
    end
    mismatches++;
  endtask

  task automatic queue_point(logic enable);
    point_t p;
    logic   in_clip;
    in_clip = pos_x >= 0 && pos_y >= 0 &&
              int'(pos_x) < int'(clip_w) && int'(pos_y) < int'(clip_h);
    p.body.x     = pos_x;
    p.body.y     = pos_y;
    p.body.addr  = AddrBits'(int'(pos_y) * int'(stride) + int'(pos_x));
    p.body.color = fill_color;
    p.flags.write_en = enable && in_clip;
    p.flags.done     = (pos_x == goal_x) && (pos_y == goal_y);
    if (p.flags.done) begin
      drawing = 1'b0;
    end
    expected_points.push_back(p);
  endtask

  task automatic trace_step(req_e kind, endpoints_t ends);
    int e2;
    int dx;
    int dy;
    if (kind == ReqStart) begin
      pos_x  = ends.start_x;
      pos_y  = ends.start_y;
      goal_x = ends.end_x;
      goal_y = ends.end_y;
      dx = int'(goal_x) - int'(pos_x);
      dy = int'(goal_y) - int'(pos_y);
      span_x = (COORD_BITS+1)'(dx < 0 ? -dx : dx);
      span_y = (COORD_BITS+1)'(dy < 0 ? -dy : dy);
      step_x_neg = !(pos_x < goal_x);
      step_y_neg = !(pos_y < goal_y);
      err = (COORD_BITS+3)'(int'(span_x) - int'(span_y));
      drawing = 1'b1;
      queue_point(1'b1);
    end else if (!drawing) begin
      // no line in progress: hold the point, never write it
      queue_point(1'b0);
    end else begin
      e2 = 2 * int'(err);
      if (e2 > -int'(span_y)) begin
        err   = (COORD_BITS+3)'(int'(err) - int'(span_y));
        pos_x = step_x_neg ? pos_x - coord_t'(1) : pos_x + coord_t'(1);
      end
      if (e2 < int'(span_x)) begin
        err   = (COORD_BITS+3)'(int'(err) + int'(span_x));
        pos_y = step_y_neg ? pos_y - coord_t'(1) : pos_y + coord_t'(1);
      end
      queue_point(1'b1);
    end
  endtask

  task automatic check_point();
    point_t      want;
    pixel_beat_t got;
    got = pixel_beat_t'(m_axis_tdata[$bits(pixel_beat_t)-1:0]);
    beats_seen++;
    if (expected_points.size() == 0) begin
      report_mismatch("beat with no point owed", '0, '0);
    end else begin
      want = expected_points.pop_front();
      if (got.x !== want.body.x) report_mismatch("pixel_x", got.x, want.body.x);
      if (got.y !== want.body.y) report_mismatch("pixel_y", got.y, want.body.y);
      if (got.addr !== want.body.addr) begin
        report_mismatch("word_address", got.addr, want.body.addr);
      end
      if (got.color !== want.body.color) begin
        report_mismatch("pixel_color", got.color, want.body.color);
      end
      if (m_axis_tuser !== want.flags.write_en) begin
        report_mismatch("write_enable", m_axis_tuser, want.flags.write_en);
      end
      if (m_axis_tlast !== want.flags.done) begin
        report_mismatch("line_done", m_axis_tlast, want.flags.done);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride     = StrideReset;
      fill_color = ColorReset;
      clip_w     = ClipWReset;
      clip_h     = ClipHReset;
      pos_x      = '0;
      pos_y      = '0;
      goal_x     = '0;
      goal_y     = '0;
      span_x     = '0;
      span_y     = '0;
      step_x_neg = 1'b0;
      step_y_neg = 1'b0;
      err        = '0;
      drawing    = 1'b0;
      expected_points.delete();
      points_pending_o <= 0;
    end else begin
      // output first: a point can never leave in the cycle its request enters
      if (m_axis_tvalid && m_axis_tready) begin
        check_point();
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgStride: stride     = cfg_wdata_i[StrideBits-1:0];
          CfgColor:  fill_color = cfg_wdata_i[ColorBits-1:0];
          CfgClipW:  clip_w     = cfg_wdata_i[ClipBits-1:0];
          CfgClipH:  clip_h     = cfg_wdata_i[ClipBits-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        trace_step(req_e'(s_axis_tuser),
                   endpoints_t'(s_axis_tdata[$bits(endpoints_t)-1:0]));
      end
      points_pending_o <= expected_points.size();
    end
  end

endmodule

// ===== tb/sv/tb_bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// tb_bresenham_line_rasterizer
// Drives the line rasterizer with a directed set of lines (extreme endpoints,
// single-point lines, clip edges, negative coordinates, advances with no line)
// and then with random phases of short complete lines, long lines cut short
// and stray advances, under several register settings. Both stream sides
// idle at random; a long output hold-off fills the block. The checker beside
// the block predicts and compares every point.
// ----------------------------------------------------------------------------
module tb_bresenham_line_rasterizer;
  import brl_pkg::*;

  localparam int unsigned CoordBits = CoordBitsDefault;
  localparam int unsigned InBits    = ((4*CoordBits+7)/8)*8;
  localparam int unsigned OutBits   = ((2*CoordBits+AddrBits+ColorBits+7)/8)*8;
  localparam int CoordMax   = (1 << (CoordBits-1)) - 1;
  localparam int CoordMin   = -(1 << (CoordBits-1));
  localparam int NumPhases  = 7;
  localparam int PhaseItems = 250;
  localparam int MaxWait    = 13;
  localparam int HoldCycles = 300;
  localparam int MaxSpan    = 24;

  typedef logic signed [CoordBits-1:0] coord_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index_i   = CfgStride;
  logic [CfgDataBits-1:0]  cfg_wdata_i   = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InBits-1:0]       s_axis_tdata  = '0;
  logic                    s_axis_tuser  = ReqStart;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutBits-1:0]      m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tlast;

  int   mismatch_count;
  int   points_pending;
  logic no_idle       = 1'b0;
  int   hold_requests = 0;
  int   items_sent    = 0;
  int   clip_x_now    = 600;
  int   clip_y_now    = 600;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bresenham_line_rasterizer #(.COORD_BITS(CoordBits)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  bresenham_point_checker #(.COORD_BITS(CoordBits)) point_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .mismatch_count_o(mismatch_count),
    .points_pending_o(points_pending)
  );

  // called and returning at a falling edge
  task automatic send_req(req_e kind, int sx, int sy, int ex, int ey);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = InBits'({coord_t'(ey), coord_t'(ex), coord_t'(sy), coord_t'(sx)});
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_line(int sx, int sy, int ex, int ey, int advances);
    send_req(ReqStart, sx, sy, ex, ey);
    repeat (advances) begin
      // endpoint fields of an advance are don't-care: fill them with noise
      send_req(ReqAdvance, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic drain_points();
    s_axis_tvalid = 1'b0;
    do @(negedge clk_i); while (points_pending != 0);
  endtask

  task automatic program_window(int stride, logic [31:0] color, int cw, int ch);
    cfg_we_i    = 1'b1;
    cfg_index_i = CfgStride;
    cfg_wdata_i = CfgDataBits'(stride);
    @(negedge clk_i);
    cfg_index_i = CfgColor;
    cfg_wdata_i = color;
    @(negedge clk_i);
    cfg_index_i = CfgClipW;
    cfg_wdata_i = CfgDataBits'(cw);
    @(negedge clk_i);
    cfg_index_i = CfgClipH;
    cfg_wdata_i = CfgDataBits'(ch);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    clip_x_now = cw % (1 << ClipBits);
    clip_y_now = ch % (1 << ClipBits);
  endtask

  function automatic int pick_coord(int edge_pos);
    int r;
    r = int'($urandom_range(0, 2*MaxSpan));
    case ($urandom_range(0, 9))
      0, 1, 2: return int'($urandom_range(0, 700));
      3:       return edge_pos + r - MaxSpan;
      4:       return r - MaxSpan;
      5:       return $urandom_range(0, 1) ? CoordMax - r : CoordMin + r;
      default: return int'(coord_t'($urandom));
    endcase
  endfunction

  function automatic int offset_coord(int base);
    int v;
    v = int'(coord_t'(base)) + int'($urandom_range(0, 2*MaxSpan)) - MaxSpan;
    if (v > CoordMax) v = CoordMax;
    if (v < CoordMin) v = CoordMin;
    return v;
  endfunction

  // output side: per-beat stall, with an occasional long hold-off
  initial begin : sink
    int stall;
    int holds_done;
    holds_done = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_requests > holds_done) begin
        holds_done++;
        stall = HoldCycles;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, MaxWait);
      end
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int sx, sy, ex, ey;
    int steps;
    int extra;
    int dx, dy;
    int pick;
    int goal;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // advance with no line, single-point line, extremes, clip edge, octants
    send_req(ReqAdvance, -1, -1, -1, -1);
    send_line(5, 5, 5, 5, 1);
    send_line(CoordMin, CoordMin, CoordMax, CoordMax, 2);
    send_line(CoordMax, CoordMin, CoordMin, CoordMax, 1);
    send_line(599, 599, 600, 600, 2);
    send_line(-1, 0, 1, 0, 2);
    send_line(3, 0, 0, 2, 3);
    send_line(10, 20, 11, 14, 2);

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_points();
      case (phase)
        0:       program_window(1, 32'h0000_0000, 2047, 2047);
        1:       program_window(4096, 32'hFFFF_FFFF, 1, 1);
        2:       program_window(0, $urandom, 2048, 600);
        3:       program_window(8191, $urandom, 640, 2048);
        4:       program_window(640, $urandom, 640, 480);
        default: program_window($urandom_range(1, 4096), $urandom,
                                $urandom_range(1, 2048), $urandom_range(1, 2048));
      endcase
      if (phase == 1 || phase == 4) begin
        hold_requests++;
        no_idle = 1'b1;
      end
      goal = items_sent + PhaseItems;
      while (items_sent < goal) begin
        if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_req(ReqAdvance, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 18) begin
          // long line, abandoned part way by the next start
          send_line($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 30));
        end else begin
          sx = pick_coord(clip_x_now);
          sy = pick_coord(clip_y_now);
          ex = offset_coord(sx);
          ey = offset_coord(sy);
          dx = int'(coord_t'(ex)) - int'(coord_t'(sx));
          dy = int'(coord_t'(ey)) - int'(coord_t'(sy));
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          steps = dx > dy ? dx : dy;
          if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
          extra = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3);
          send_line(sx, sy, ex, ey, steps + extra);
        end
        if ($urandom_range(0, 99) == 0) drain_points();
      end
    end

    drain_points();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
